// File: hdl/biop_message_header_parser_top_defines.svh
// Assertion macros used by the BIOP header parser RTL.
`ifndef BIOP_MESSAGE_HEADER_PARSER_TOP_DEFINES_SVH
`define BIOP_MESSAGE_HEADER_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BIOP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("biop header parser: implication check failed");
// Next-cycle implication.
`define BIOP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("biop header parser: next-cycle check failed");
`else
`define BIOP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BIOP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/biop_hdr_pkg.sv
// Types and constants of the BIOP message header parser.
package biop_hdr_pkg;

   localparam logic [31:0] MAGIC_RESET    = 32'h4249_4F50;
   localparam logic [31:0] POS_MAJOR      = 32'd4;
   localparam logic [31:0] POS_MINOR      = 32'd5;
   localparam logic [31:0] POS_TYPE       = 32'd7;
   localparam logic [31:0] POS_SIZE       = 32'd8;
   localparam logic [31:0] POS_KEY_LENGTH = 32'd12;
   localparam logic [31:0] POS_KEY        = 32'd13;
   localparam logic [31:0] MIN_LENGTH     = 32'd13;
   localparam logic [32:0] SIZE_BIAS      = 33'd12;
   localparam logic [31:0] KIND_LENGTH_OK = 32'd4;
   localparam logic [31:0] POS_MAX        = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_BAD_MAGIC = 3'd2,
      ST_ZERO_KEY  = 3'd3,
      ST_BAD_KIND  = 3'd4,
      ST_TRUNCATED = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  major_version;
      logic [7:0]  minor_version;
      logic [7:0]  message_type;
      logic [31:0] message_size;
      logic [32:0] total_length;
      logic [31:0] object_key;
      logic [31:0] object_kind;
      logic [15:0] info_length;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] byte_position;
      logic [31:0] magic_shift;
      logic [7:0]  major;
      logic [7:0]  minor;
      logic [7:0]  msg_type;
      logic [31:0] size;
      logic [7:0]  key_length;
      logic [31:0] key;
      logic [31:0] kind_length;
      logic [31:0] kind;
      logic [15:0] info_length;
   } parse_state_type;

endpackage

// File: hdl/biop_hdr_field_capture.sv
// Next-state logic of the header field registers for one incoming byte.
module biop_hdr_field_capture
   import biop_hdr_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      data_byte,
   output parse_state_type nxt_state
);

   logic [31:0] pos;
   logic [31:0] key_len_ext;
   logic [31:0] key_off;
   logic [31:0] body_off;

   assign pos         = cur_state.byte_position;
   assign key_len_ext = {24'd0, cur_state.key_length};
   assign key_off     = pos - POS_KEY;
   assign body_off    = key_off - key_len_ext;

   always_comb begin
      nxt_state = cur_state;
      priority if (pos < POS_MAJOR) begin
         nxt_state.magic_shift = {cur_state.magic_shift[23:0], data_byte};
      end else if (pos == POS_MAJOR) begin
         nxt_state.major = data_byte;
      end else if (pos == POS_MINOR) begin
         nxt_state.minor = data_byte;
      end else if (pos == POS_TYPE) begin
         nxt_state.msg_type = data_byte;
      end else if (pos >= POS_SIZE && pos < POS_KEY_LENGTH) begin
         nxt_state.size = {cur_state.size[23:0], data_byte};
      end else if (pos == POS_KEY_LENGTH) begin
         nxt_state.key_length = data_byte;
      end else if (pos >= POS_KEY && cur_state.key_length != 8'd0) begin
         // key bytes first, then kind length, kind and info length
         if (key_off < key_len_ext) begin
            if (key_off < 32'd4) begin
               nxt_state.key = {cur_state.key[23:0], data_byte};
            end
         end else if (body_off < 32'd4) begin
            nxt_state.kind_length = {cur_state.kind_length[23:0], data_byte};
         end else if (body_off < 32'd8) begin
            nxt_state.kind = {cur_state.kind[23:0], data_byte};
         end else if (body_off < 32'd10) begin
            nxt_state.info_length = {cur_state.info_length[7:0], data_byte};
         end
      end
      // saturate the byte count
      if (pos != POS_MAX) begin
         nxt_state.byte_position = pos + 32'd1;
      end
   end

endmodule

// File: hdl/biop_message_header_parser_top.sv
// Top level of the BIOP message header parser.
//
// Usage: feed the bytes of a DSM-CC BIOP message buffer on the req_ channel,
// one item per byte in buffer order. first_byte restarts the parse, last_byte
// closes the buffer. Each last byte produces one rsp_ item carrying a status
// code and the header fields (versions, type, message size, total length,
// object key, object kind, info length); other bytes produce nothing.
// Throughput: one byte per clock cycle unless a held result stalls req_. Each
// byte costs a position decode and a store into the field registers, done in
// a single pass between the parse registers and the output register.
// Latency: the result appears on rsp_ the cycle after the last byte is taken.
// Stall: the output register holds a pending result; req_ready stays high
// while that register is empty or being emptied in the same cycle, so a
// stalled receiver back-pressures the byte stream after one result.
// Reset: synchronous, active high; clears the parse state and the output
// valid, and loads the expected magic word with ASCII "BIOP". csr_ writes
// replace the magic word and are always taken (csr_ready is tied high).
`include "biop_message_header_parser_top_defines.svh"

module biop_message_header_parser_top
   import biop_hdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   logic [31:0]     magic_ff;
   parse_state_type parse_ff;
   parse_state_type cur_state;
   parse_state_type nxt_state;
   logic            rsp_valid_ff;
   rsp_item_type    rsp_data_ff;
   rsp_item_type    rsp_data_in;
   logic            req_accept;
   logic            head_ok;
   logic            body_ok;
   status_type      status_in;
   logic [32:0]     len_ext;
   logic [32:0]     total_in;
   logic [32:0]     kind_end;
   logic [32:0]     info_end;

   // accept a byte while the output register is free or draining
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // a first byte starts the parse from a clean state
   assign cur_state = req_data.first_byte ? parse_state_type'('0) : parse_ff;

   biop_hdr_field_capture u_capture (
      .cur_state (cur_state),
      .data_byte (req_data.data_byte),
      .nxt_state (nxt_state)
   );

   // length checks run on the count including this byte
   assign len_ext  = {1'b0, nxt_state.byte_position};
   assign total_in = {1'b0, nxt_state.size} + SIZE_BIAS;
   assign kind_end = {1'b0, MIN_LENGTH} + {25'd0, nxt_state.key_length} + 33'd4;
   assign info_end = {1'b0, MIN_LENGTH} + {25'd0, nxt_state.key_length} + 33'd10;

   always_comb begin
      head_ok   = 1'b0;
      body_ok   = 1'b0;
      status_in = ST_OK;
      priority if (nxt_state.byte_position < MIN_LENGTH) begin
         status_in = ST_SHORT;
      end else if (nxt_state.magic_shift != magic_ff) begin
         status_in = ST_BAD_MAGIC;
      end else begin
         head_ok = 1'b1;
         priority if (len_ext < total_in) begin
            status_in = ST_TRUNCATED;
         end else if (nxt_state.key_length == 8'd0) begin
            status_in = ST_ZERO_KEY;
         end else if (len_ext < kind_end) begin
            status_in = ST_TRUNCATED;
         end else if (nxt_state.kind_length != KIND_LENGTH_OK) begin
            status_in = ST_BAD_KIND;
         end else if (len_ext < info_end) begin
            status_in = ST_TRUNCATED;
         end else begin
            body_ok = 1'b1;
         end
      end
   end

   // zero the fields that the status says are not valid
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in.status = status_in;
      if (head_ok) begin
         rsp_data_in.major_version = nxt_state.major;
         rsp_data_in.minor_version = nxt_state.minor;
         rsp_data_in.message_type  = nxt_state.msg_type;
         rsp_data_in.message_size  = nxt_state.size;
         rsp_data_in.total_length  = total_in;
      end
      if (body_ok) begin
         rsp_data_in.object_key  = nxt_state.key;
         rsp_data_in.object_kind = nxt_state.kind;
         rsp_data_in.info_length = nxt_state.info_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= MAGIC_RESET;
         parse_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            magic_ff <= csr_data;
         end
         if (req_accept) begin
            // a last byte ends the buffer: drop the parse state
            parse_ff <= req_data.last_byte ? parse_state_type'('0) : nxt_state;
         end
         if (req_accept && req_data.last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (req_accept && req_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `BIOP_ASSERT_NEXT(a_last_gives_result, clock, reset, req_accept && req_data.last_byte, rsp_valid_ff)
   `BIOP_ASSERT_NEXT(a_last_clears_count, clock, reset, req_accept && req_data.last_byte, parse_ff.byte_position == 32'd0)
   `BIOP_ASSERT_IMPLY(a_error_body_zero, clock, reset, rsp_valid_ff && rsp_data_ff.status != ST_OK, rsp_data_ff.object_key == 32'd0 && rsp_data_ff.object_kind == 32'd0 && rsp_data_ff.info_length == 16'd0)
   `BIOP_ASSERT_IMPLY(a_early_error_head_zero, clock, reset, rsp_valid_ff && (rsp_data_ff.status == ST_SHORT || rsp_data_ff.status == ST_BAD_MAGIC), rsp_data_ff.total_length == 33'd0)

endmodule
